// ===== sv/stain_colour_deconvolution_core_assert.svh =====
// Assertion macros used by the checker of the stain deconvolution core.
`ifndef STAIN_COLOUR_DECONVOLUTION_CORE_ASSERT_SVH
`define STAIN_COLOUR_DECONVOLUTION_CORE_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define SCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// Next-cycle implication, ignored while reset is held.
`define SCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

// Same-cycle implication that also holds across reset.
`define SCD_ASSERT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |-> (cons)) \
        else $error("%m: reset check failed");

`endif

// ===== sv/scd_pkg.sv =====
`default_nettype none

package scd_pkg;

    localparam int PIX_W      = 8;
    localparam int COEF_W     = 18;
    localparam int OD_W       = 17;
    localparam int PROD_W     = OD_W + COEF_W;
    localparam int DENS_W     = PROD_W + 2;
    localparam int DSAT_W     = 31;
    localparam int ROW_W      = 3 * COEF_W;
    localparam int CFG_ADDR_W = 2;
    localparam int CNT_W      = 8;
    localparam int TBL_N      = 256;

    localparam logic [63:0] Q30_ONE    = 64'd1 << 30;
    localparam logic [63:0] LN2_Q30    = 64'd744261118;
    localparam logic [63:0] DENS_SCALE = 64'd255 << 22;
    localparam logic [63:0] DENS_HIGH  = 64'd300 << 22;

    // Saturated density code for anything above the upper limit.
    localparam logic [DSAT_W-1:0] DSAT_OVER = DSAT_W'(DENS_HIGH + 64'd1);

    localparam logic [ROW_W-1:0] COEF_FIRST_RST  = ROW_W'(64'h0000_0000_0000_4000);
    localparam logic [ROW_W-1:0] COEF_SECOND_RST = ROW_W'(64'h0000_0001_0000_0000);
    localparam logic [ROW_W-1:0] COEF_THIRD_RST  = ROW_W'(64'h0004_0000_0000_0000);

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ROW_FIRST  = 2'd0,
        CFG_ROW_SECOND = 2'd1,
        CFG_ROW_THIRD  = 2'd2
    } cfg_idx_t;

    typedef struct packed {
        logic [PIX_W-1:0] red_in;
        logic [PIX_W-1:0] green_in;
        logic [PIX_W-1:0] blue_in;
    } pixel_t;

    typedef struct packed {
        logic [PIX_W-1:0] stain_first;
        logic [PIX_W-1:0] stain_second;
        logic [PIX_W-1:0] stain_third;
    } stain_t;

    // [0] red weight, [1] green, [2] blue: matches the register bit layout.
    typedef logic [2:0][COEF_W-1:0]  coef_row_t;
    typedef coef_row_t [2:0]         coef_mat_t;
    typedef logic [2:0][DSAT_W-1:0]  dens_vec_t;

    typedef logic [TBL_N-1:0][OD_W-1:0]   od_table_t;
    typedef logic [TBL_N-1:0][DSAT_W-1:0] thr_table_t;

    // Restoring divider, elaboration use only.
    function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], num[i]};
            if (rem >= den) begin
                rem  = rem - den;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // ln(n) in Q3.30 for n = 1..256 via k*ln2 + 2*atanh(z).
    function automatic logic [63:0] ln_q30(input logic [8:0] n);
        logic [63:0] m;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [3:0]  k;
        k = '0;
        for (int j = 0; j < 8; j++) begin
            if ((n >> (k + 4'd1)) != 9'd0) begin
                k = k + 4'd1;
            end
        end
        m    = ({55'd0, n} << 30) >> k;
        z    = udiv64((m - Q30_ONE) << 30, m + Q30_ONE);
        z2   = (z * z) >> 30;
        term = z;
        sum  = '0;
        for (int i = 1; term != 64'd0 && i < 200; i += 2) begin
            sum  = sum + udiv64(term, 64'(i));
            term = (term * z2) >> 30;
        end
        return (sum << 1) + 64'(k) * LN2_Q30;
    endfunction

    // Optical density in Q9.8, ties away from zero.
    function automatic logic [OD_W-1:0] density_q8(input logic [PIX_W-1:0] p);
        logic [63:0] l255;
        logic [63:0] lp;
        logic [63:0] mag;
        logic [63:0] q;
        logic        neg;
        l255 = ln_q30(9'd255);
        lp   = ln_q30({1'b0, p} + 9'd1);
        neg  = lp > l255;
        mag  = neg ? (lp - l255) : (l255 - lp);
        q    = udiv64(mag * 64'd65280 + (l255 >> 1), l255);
        return neg ? OD_W'(64'd0 - q) : OD_W'(q);
    endfunction

    function automatic od_table_t build_od_table();
        od_table_t tbl;
        for (int p = 0; p < TBL_N; p++) begin
            tbl[p] = density_q8(PIX_W'(p));
        end
        return tbl;
    endfunction

    function automatic logic [63:0] exp_q30(input logic [63:0] r);
        logic [63:0] sum;
        logic [63:0] term;
        sum  = Q30_ONE;
        term = Q30_ONE;
        for (int i = 1; term != 64'd0 && i < 64; i++) begin
            term = udiv64((term * r) >> 30, 64'(i));
            sum  = sum + term;
        end
        return sum;
    endfunction

    // Intensity for a density 1..DENS_HIGH in Q.22.
    function automatic logic [CNT_W-1:0] intensity_ref(input logic [63:0] d,
                                                      input logic [63:0] l255);
        logic [63:0] t;
        logic [63:0] k;
        logic [63:0] r;
        logic [63:0] y;
        t = (d * l255) / DENS_SCALE;
        k = t / LN2_Q30;
        r = t - k * LN2_Q30;
        y = 64'd255 * udiv64(64'd1 << 60, exp_q30(r));
        if (k > 64'd40) begin
            return '0;
        end
        y = y >> k;
        y = (y + (64'd1 << 29)) >> 30;
        return (y > 64'd255) ? CNT_W'(255) : y[CNT_W-1:0];
    endfunction

    // Entry j: smallest clamped density whose intensity is at most 255 - j.
    function automatic thr_table_t build_thr_table();
        thr_table_t  tbl;
        logic [63:0] l255;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        tbl  = '0;
        l255 = ln_q30(9'd255);
        lo   = 64'd1;
        for (int j = 1; j < TBL_N; j++) begin
            hi = DENS_HIGH + 64'd1;
            while (lo < hi) begin
                mid = (lo + hi) >> 1;
                if (int'(intensity_ref(mid, l255)) <= 255 - j) begin
                    hi = mid;
                end else begin
                    lo = mid + 64'd1;
                end
            end
            tbl[j] = DSAT_W'(lo);
        end
        return tbl;
    endfunction

    localparam od_table_t  OD_TABLE  = build_od_table();
    localparam thr_table_t THR_TABLE = build_thr_table();

endpackage

`default_nettype wire

// ===== sv/stain_colour_deconvolution_core.sv =====
// Throughput: one pixel per cycle while the output is not stalled; 11 register stages
// (OD lookup, 3x3 multiply, row sum/clamp, 8 threshold search) each take a new request.
// Reset (aresetn low, synchronous): stage valid bits clear and the three coefficient
// rows return to the identity matrix. No clearing pass; all tables are constants.
`default_nettype none

module stain_colour_deconvolution_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    // pixel request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  scd_pkg::pixel_t                 s_pixel,
    // stain result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output scd_pkg::stain_t                 m_stain,
    // coefficient write port
    input  logic                            cfg_wr_en,
    input  logic [scd_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [scd_pkg::ROW_W-1:0]       cfg_wdata
);
    import scd_pkg::*;

    // Inverse stain matrix, one signed Q4.14 row per stain. Software must only
    // rewrite it while the pipeline is drained; the block does not enforce this.
    coef_mat_t coef_rows;

    // Clamped stain densities between the two halves of the pipeline.
    logic      dens_valid;
    logic      dens_ready;
    dens_vec_t dens;

    scd_coef_regs u_coef_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .coef_rows (coef_rows)
    );

    // Front half: per-channel optical density from a 256-entry constant table,
    // nine 17x18 signed products, then the three row sums. Each sum is clamped
    // to zero when not positive and to one past the density limit above it,
    // so the search below only ever sees a 31-bit unsigned code.
    scd_density u_density (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pixel  (s_pixel),
        .coef_rows (coef_rows),
        .out_valid (dens_valid),
        .out_ready (dens_ready),
        .out_dens  (dens)
    );

    // Back half: intensity is monotone in density, so 255 - intensity is found
    // by a binary search against precomputed density thresholds, one bit per
    // stage. The last stage is the output register.
    scd_intensity u_intensity (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (dens_valid),
        .in_ready  (dens_ready),
        .in_dens   (dens),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_stain (m_stain)
    );

endmodule

`default_nettype wire

// ===== sv/scd_coef_regs.sv =====
`default_nettype none

module scd_coef_regs (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   cfg_wr_en,
    input  logic [scd_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  logic [scd_pkg::ROW_W-1:0]              cfg_wdata,
    output scd_pkg::coef_mat_t                     coef_rows
);
    import scd_pkg::*;

    coef_mat_t rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rows_reg[0] <= COEF_FIRST_RST;
            rows_reg[1] <= COEF_SECOND_RST;
            rows_reg[2] <= COEF_THIRD_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                CFG_ROW_FIRST: begin
                    rows_reg[0] <= cfg_wdata;
                end
                CFG_ROW_SECOND: begin
                    rows_reg[1] <= cfg_wdata;
                end
                CFG_ROW_THIRD: begin
                    rows_reg[2] <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    assign coef_rows = rows_reg;

endmodule

`default_nettype wire

// ===== sv/scd_density.sv =====
`default_nettype none

// Three stages: OD lookup, 3x3 products, row sums with clamp.
module scd_density (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  scd_pkg::pixel_t      in_pixel,
    input  scd_pkg::coef_mat_t   coef_rows,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scd_pkg::dens_vec_t   out_dens
);
    import scd_pkg::*;

    localparam logic signed [DENS_W-1:0] DENS_HIGH_S = DENS_W'(DENS_HIGH);

    logic [2:0] vld_reg;
    logic [2:0] vld_in;
    logic [2:0] adv;

    logic [2:0][OD_W-1:0]             od_reg;
    logic [2:0][OD_W-1:0]             od_next;
    logic [2:0][2:0][PROD_W-1:0]      prod_reg;
    logic [2:0][2:0][PROD_W-1:0]      prod_next;
    dens_vec_t                        dens_reg;
    dens_vec_t                        dens_next;
    logic [2:0][PIX_W-1:0]            chan;
    logic signed [2:0][DENS_W-1:0]    row_sum;

    // Bubble-collapsing handshake.
    always_comb begin
        adv[2] = !vld_reg[2] || out_ready;
        adv[1] = !vld_reg[1] || adv[2];
        adv[0] = !vld_reg[0] || adv[1];
    end

    assign vld_in   = {vld_reg[1:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int s = 0; s < 3; s++) begin
                if (adv[s]) begin
                    vld_reg[s] <= vld_in[s];
                end
            end
        end
    end

    always_comb begin
        chan[0] = in_pixel.red_in;
        chan[1] = in_pixel.green_in;
        chan[2] = in_pixel.blue_in;
        for (int c = 0; c < 3; c++) begin
            od_next[c] = OD_TABLE[chan[c]];
        end
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                prod_next[r][c] = PROD_W'($signed(od_reg[c]) * $signed(coef_rows[r][c]));
            end
        end
        for (int r = 0; r < 3; r++) begin
            row_sum[r] = DENS_W'($signed(prod_reg[r][0]))
                       + DENS_W'($signed(prod_reg[r][1]))
                       + DENS_W'($signed(prod_reg[r][2]));
            // element selects are unsigned; compare as two's complement
            if ($signed(row_sum[r]) <= 0) begin
                dens_next[r] = '0;
            end else if ($signed(row_sum[r]) > DENS_HIGH_S) begin
                dens_next[r] = DSAT_OVER;
            end else begin
                dens_next[r] = row_sum[r][DSAT_W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv[0]) begin
            od_reg <= od_next;
        end
        if (adv[1]) begin
            prod_reg <= prod_next;
        end
        if (adv[2]) begin
            dens_reg <= dens_next;
        end
    end

    assign out_valid = vld_reg[2];
    assign out_dens  = dens_reg;

endmodule

`default_nettype wire

// ===== sv/scd_intensity.sv =====
`default_nettype none

// Eight-stage threshold search: each stage settles one bit of 255 - intensity.
module scd_intensity (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  scd_pkg::dens_vec_t   in_dens,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scd_pkg::stain_t      out_stain
);
    import scd_pkg::*;

    function automatic logic [CNT_W-1:0] search_step(input logic [DSAT_W-1:0] d,
                                                    input logic [CNT_W-1:0]  cnt,
                                                    input logic [CNT_W-1:0]  probe);
        logic [CNT_W-1:0] cand;
        cand = cnt | probe;
        return (d >= THR_TABLE[cand]) ? cand : cnt;
    endfunction

    logic [CNT_W-1:0] vld_reg;
    logic [CNT_W-1:0] vld_in;
    logic [CNT_W-1:0] adv;

    logic [CNT_W-1:0][2:0][CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0][2:0][CNT_W-1:0] cnt_next;
    logic [CNT_W-2:0][2:0][DSAT_W-1:0] dens_reg;
    logic [CNT_W-2:0][2:0][DSAT_W-1:0] dens_next;

    always_comb begin
        adv[CNT_W-1] = !vld_reg[CNT_W-1] || out_ready;
        for (int s = CNT_W - 2; s >= 0; s--) begin
            adv[s] = !vld_reg[s] || adv[s+1];
        end
    end

    assign vld_in   = {vld_reg[CNT_W-2:0], in_valid};
    assign in_ready = adv[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            for (int s = 0; s < CNT_W; s++) begin
                if (adv[s]) begin
                    vld_reg[s] <= vld_in[s];
                end
            end
        end
    end

    always_comb begin
        dens_next[0] = in_dens;
        for (int l = 0; l < 3; l++) begin
            cnt_next[0][l] = search_step(in_dens[l], '0, CNT_W'(1) << (CNT_W - 1));
        end
        for (int s = 1; s < CNT_W; s++) begin
            for (int l = 0; l < 3; l++) begin
                cnt_next[s][l] = search_step(dens_reg[s-1][l], cnt_reg[s-1][l],
                                             CNT_W'(1) << (CNT_W - 1 - s));
            end
        end
        for (int s = 1; s < CNT_W - 1; s++) begin
            dens_next[s] = dens_reg[s-1];
        end
    end

    always_ff @(posedge aclk) begin
        for (int s = 0; s < CNT_W; s++) begin
            if (adv[s]) begin
                cnt_reg[s] <= cnt_next[s];
            end
        end
        for (int s = 0; s < CNT_W - 1; s++) begin
            if (adv[s]) begin
                dens_reg[s] <= dens_next[s];
            end
        end
    end

    assign out_valid              = vld_reg[CNT_W-1];
    assign out_stain.stain_first  = ~cnt_reg[CNT_W-1][0];
    assign out_stain.stain_second = ~cnt_reg[CNT_W-1][1];
    assign out_stain.stain_third  = ~cnt_reg[CNT_W-1][2];

endmodule

`default_nettype wire

// ===== sv/scd_core_checker.sv =====
`default_nettype none

`include "stain_colour_deconvolution_core_assert.svh"

module scd_core_checker (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_ready,
    input  logic            m_valid,
    input  logic            m_ready,
    input  scd_pkg::stain_t m_stain
);

    // A stalled result stays up with the same value.
    `SCD_ASSERT_NEXT(a_hold_valid, aclk, aresetn, m_valid && !m_ready, m_valid)
    `SCD_ASSERT_NEXT(a_hold_data, aclk, aresetn, m_valid && !m_ready, $stable(m_stain))

    // Input backpressure only when every stage is full and the output is stalled.
    `SCD_ASSERT_NOW(a_full_only, aclk, aresetn, !s_ready, m_valid && !m_ready)

    // Nothing leaves the pipeline on the first cycle out of reset.
    `SCD_ASSERT_ALWAYS(a_reset_empty, aclk, $rose(aresetn), !m_valid)

endmodule

bind stain_colour_deconvolution_core scd_core_checker u_scd_core_checker (.*);

`default_nettype wire

// ===== sim/stain_colour_deconvolution_core_tb.sv =====
module stain_colour_deconvolution_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::*;

    // Q3.30 fixed point helpers for the log/exp math
    localparam longint unsigned ONE_Q30   = 64'd1 << 30;
    localparam longint unsigned LOG2_Q30  = 64'd744261118;
    localparam longint          DENS_CEIL = 64'sd300 <<< 22;

    // cfg_addr is 2 bits wide; the top code selects no register
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_ROW = 2'd3;

    // cycles with work outstanding but no handshake before giving up
    localparam int STALL_LIMIT = 4000;
    // pipeline depth plus margin
    localparam int DRAIN_CYCLES = 20;

    typedef enum logic [1:0] {RX_FLOW, RX_CHOPPY, RX_CHOKED} rx_mode_e;

    logic            aclk      = 1'b0;
    logic            aresetn   = 1'b0;
    logic            s_valid   = 1'b0;
    logic            s_ready;
    pixel_t          s_pixel   = '0;
    logic            m_valid;
    logic            m_ready   = 1'b0;
    stain_t          m_stain;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [ROW_W-1:0]      cfg_wdata = '0;

    stain_colour_deconvolution_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_pixel   (s_pixel),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_stain   (m_stain),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Local copy of the block's math: optical density per channel, one
    // dot product per stain row, then 255^(1 - d/255) rounded.
    // ------------------------------------------------------------------
    longint unsigned ln255_q30;
    longint          od_lut [0:255];       // Q9.8 optical density per level
    logic [ROW_W-1:0] weight_rows [0:2];   // mirror of the coefficient rows

    // ln(n) in Q3.30: n = 2^k * m, ln m = 2*atanh((m-1)/(m+1)), terms truncated
    function automatic longint unsigned log_q30(int unsigned n);
        longint unsigned m, z, z2, term, acc;
        int unsigned     k;
        k   = 0;
        acc = 0;
        while (k < 8 && (n >> (k + 1)) != 0)
            k++;
        m    = (64'(n) << 30) >> k;
        z    = ((m - ONE_Q30) << 30) / (m + ONE_Q30);
        z2   = (z * z) >> 30;
        term = z;
        for (longint unsigned i = 1; term != 0 && i < 200; i += 2) begin
            acc  = acc + term / i;
            term = (term * z2) >> 30;
        end
        return 2 * acc + 64'(k) * LOG2_Q30;
    endfunction

    // round(255*256*ln(255/(p+1))/ln255), ties away from zero
    function automatic longint optical_density(int unsigned p);
        longint l255, lp, num;
        l255 = longint'(ln255_q30);
        lp   = longint'(log_q30(p + 1));
        num  = (l255 - lp) * 255 * 256;
        if (num >= 0)
            return (num + l255 / 2) / l255;
        return -((-num + l255 / 2) / l255);
    endfunction

    // d in Q.22 -> 255 * exp(-d*ln255/255), rounded, clamped
    function automatic logic [7:0] stain_level(longint d);
        longint unsigned t, k, r, e_sum, term, y;
        if (d <= 0)
            return 8'd255;
        if (d > DENS_CEIL)
            return 8'd0;
        t     = (64'(d) * ln255_q30) / (64'd255 << 22);
        k     = t / LOG2_Q30;
        r     = t - k * LOG2_Q30;
        e_sum = ONE_Q30;
        term  = ONE_Q30;
        for (longint unsigned i = 1; term != 0 && i < 64; i++) begin
            term  = ((term * r) >> 30) / i;
            e_sum = e_sum + term;
        end
        y = 64'd255 * ((64'd1 << 60) / e_sum);
        if (k > 40)
            return 8'd0;
        y = y >> k;
        y = (y + (64'd1 << 29)) >> 30;
        return (y > 255) ? 8'd255 : y[7:0];
    endfunction

    // row layout: [17:0] red, [35:18] green, [53:36] blue, signed Q4.14
    function automatic longint row_density(logic [ROW_W-1:0] row,
                                           longint od_r, longint od_g, longint od_b);
        logic signed [COEF_W-1:0] w_r, w_g, w_b;
        w_r = row[17:0];
        w_g = row[35:18];
        w_b = row[53:36];
        return od_r * w_r + od_g * w_g + od_b * w_b;
    endfunction

    function automatic stain_t stains_for_pixel(pixel_t px);
        stain_t s;
        longint od_r, od_g, od_b;
        od_r = od_lut[px.red_in];
        od_g = od_lut[px.green_in];
        od_b = od_lut[px.blue_in];
        s.stain_first  = stain_level(row_density(weight_rows[CFG_ROW_FIRST],  od_r, od_g, od_b));
        s.stain_second = stain_level(row_density(weight_rows[CFG_ROW_SECOND], od_r, od_g, od_b));
        s.stain_third  = stain_level(row_density(weight_rows[CFG_ROW_THIRD],  od_r, od_g, od_b));
        return s;
    endfunction

    // ------------------------------------------------------------------
    // Pixel driver: pops pixels_to_send, bursts of random length with
    // random gaps in between. Changes inputs on the falling edge only.
    // ------------------------------------------------------------------
    pixel_t pixels_to_send [$];
    stain_t pending_stains [$];
    bit     req_taken  = 1'b0;   // pixel request accepted at the last rising edge
    int     burst_left = 0;
    int     gap_left   = 0;
    int     error_count = 0;
    int     quiet_cycles = 0;

    always @(negedge aclk) begin
        if (!s_valid || req_taken) begin
            if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pixels_to_send.size() > 0) begin
                s_pixel <= pixels_to_send.pop_front();
                s_valid <= 1'b1;
                if (burst_left == 0) begin
                    // new burst; about a third of them follow on with no gap
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result back-pressure: runs of free flow, choppy and heavily choked
    // ready, each lasting a random number of cycles.
    // ------------------------------------------------------------------
    rx_mode_e rx_mode      = RX_FLOW;
    int       rx_mode_left = 0;

    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_e'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(16, 96);
        end else begin
            rx_mode_left--;
        end
        case (rx_mode)
            RX_FLOW:   m_ready <= 1'b1;
            RX_CHOPPY: m_ready <= 1'($urandom_range(0, 1));
            default:   m_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ------------------------------------------------------------------
    // Monitor: on every accepted pixel request queue its stains, on every
    // accepted result compare against the oldest queued entry.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string what);
        $display("[%0t] MISMATCH %s", $realtime, what);
        error_count++;
    endtask

    task automatic check_stain(string field, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %0d want %0d", field, got, want));
    endtask

    always @(posedge aclk) begin
        stain_t want;
        bit     result_taken;
        req_taken    = aresetn && s_valid && s_ready;
        result_taken = aresetn && m_valid && m_ready;
        if (req_taken)
            pending_stains.push_back(stains_for_pixel(s_pixel));
        if (result_taken) begin
            if (pending_stains.size() == 0) begin
                report_mismatch($sformatf("result %h with no pixel outstanding", m_stain));
            end else begin
                want = pending_stains.pop_front();
                check_stain("stain_first",  m_stain.stain_first,  want.stain_first);
                check_stain("stain_second", m_stain.stain_second, want.stain_second);
                check_stain("stain_third",  m_stain.stain_third,  want.stain_third);
            end
        end
        // hang detector: only counts while something is still owed
        if (req_taken || result_taken ||
            (pixels_to_send.size() == 0 && !s_valid && pending_stains.size() == 0))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("stain_colour_deconvolution_core_tb: errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus sequencing
    // ------------------------------------------------------------------

    // register writes go out only while the pipe is empty
    task automatic write_row(logic [CFG_ADDR_W-1:0] addr, logic [ROW_W-1:0] value);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        if (addr <= CFG_ROW_THIRD)
            weight_rows[addr] = value;
    endtask

    function automatic logic [ROW_W-1:0] pack_weights(int w_r, int w_g, int w_b);
        logic [COEF_W-1:0] f_r, f_g, f_b;
        f_r = w_r[COEF_W-1:0];
        f_g = w_g[COEF_W-1:0];
        f_b = w_b[COEF_W-1:0];
        return {f_b, f_g, f_r};
    endfunction

    // mostly weights in about +-1.5 so intensities land mid-range,
    // some small, some anywhere in the 18-bit field
    function automatic int random_weight();
        case ($urandom_range(0, 3))
            0:       return int'($urandom_range(0, 8192)) - 4096;
            1:       return int'($urandom_range(0, 262143)) - 131072;
            default: return int'($urandom_range(0, 49152)) - 24576;
        endcase
    endfunction

    function automatic logic [ROW_W-1:0] random_row();
        return pack_weights(random_weight(), random_weight(), random_weight());
    endfunction

    function automatic logic [7:0] random_level();
        case ($urandom_range(0, 5))
            0:       return 8'($urandom_range(0, 3));       // dense
            1:       return 8'($urandom_range(250, 255));   // near white, od <= 0 for 254 and 255
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic pixel_t random_pixel();
        pixel_t px;
        logic [7:0] base;
        if ($urandom_range(0, 4) == 0) begin
            // grayish background tissue
            base        = 8'($urandom_range(8, 247));
            px.red_in   = base + 8'($urandom_range(0, 16)) - 8'd8;
            px.green_in = base + 8'($urandom_range(0, 16)) - 8'd8;
            px.blue_in  = base + 8'($urandom_range(0, 16)) - 8'd8;
        end else begin
            px.red_in   = random_level();
            px.green_in = random_level();
            px.blue_in  = random_level();
        end
        return px;
    endfunction

    task automatic queue_random(int count);
        @(posedge aclk);
        repeat (count) pixels_to_send.push_back(random_pixel());
    endtask

    // stimulus holds off until every queued pixel has gone out and its stain has come back
    task automatic wait_drained();
        @(negedge aclk);
        while (pixels_to_send.size() != 0 || s_valid || pending_stains.size() != 0)
            @(negedge aclk);
    endtask

    // corners of the pixel space: black, white, the od <= 0 levels,
    // primaries, secondaries and a few mixed tones (0xRRGGBB)
    logic [23:0] corner_pixels [] = '{
        24'h000000, 24'hFFFFFF, 24'hFEFEFE, 24'h010101, 24'hFF0000, 24'h00FF00,
        24'h0000FF, 24'h00FFFF, 24'hFF00FF, 24'hFFFF00, 24'h808080, 24'h7F7F7F,
        24'h55AAFF, 24'hAA5500, 24'hC89664, 24'h0A141E, 24'hFD027F, 24'h4080C0,
        24'hC04020, 24'h01FE00, 24'hFEFF01, 24'h000001, 24'hAAAAAA
    };

    initial begin
        ln255_q30 = log_q30(255);
        for (int p = 0; p < 256; p++)
            od_lut[p] = optical_density(p);
        weight_rows[CFG_ROW_FIRST]  = COEF_FIRST_RST;
        weight_rows[CFG_ROW_SECOND] = COEF_SECOND_RST;
        weight_rows[CFG_ROW_THIRD]  = COEF_THIRD_RST;

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // identity rows out of reset: each stain is one channel's od
        @(posedge aclk);
        foreach (corner_pixels[i])
            pixels_to_send.push_back(pixel_t'(corner_pixels[i]));
        queue_random(80);
        wait_drained();

        // largest positive weights: densities far above the clamp
        write_row(CFG_ROW_FIRST,  pack_weights(131071, 131071, 131071));
        write_row(CFG_ROW_SECOND, pack_weights(131071, 0, 0));
        write_row(CFG_ROW_THIRD,  pack_weights(0, 0, 131071));
        @(posedge aclk);
        foreach (corner_pixels[i])
            pixels_to_send.push_back(pixel_t'(corner_pixels[i]));
        queue_random(20);
        wait_drained();

        // most negative weights, and a row mixing both extremes
        write_row(CFG_ROW_FIRST,  pack_weights(-131072, -131072, -131072));
        write_row(CFG_ROW_SECOND, pack_weights(131071, -131072, 131071));
        write_row(CFG_ROW_THIRD,  pack_weights(-131072, 0, 16384));
        queue_random(30);
        wait_drained();

        // all-zero rows; a write to the unused index must change nothing
        write_row(CFG_ROW_FIRST,  '0);
        write_row(CFG_ROW_SECOND, '0);
        write_row(CFG_ROW_THIRD,  '0);
        write_row(CFG_NO_ROW, ROW_W'({$urandom, $urandom}));
        queue_random(20);
        wait_drained();

        // inverse of a typical hematoxylin / eosin / DAB stain matrix
        write_row(CFG_ROW_FIRST,  pack_weights(30802, -1147, -9830));
        write_row(CFG_ROW_SECOND, pack_weights(-16712, 18514, -7864));
        write_row(CFG_ROW_THIRD,  pack_weights(-9011, -2130, 25723));
        queue_random(120);
        wait_drained();

        // random rows, full-width patterns now and then
        repeat (5) begin
            write_row(CFG_ROW_FIRST,  random_row());
            write_row(CFG_ROW_SECOND,
                      ($urandom_range(0, 3) == 0) ? ROW_W'({$urandom, $urandom}) : random_row());
            write_row(CFG_ROW_THIRD,  random_row());
            if ($urandom_range(0, 1) == 0)
                write_row(CFG_NO_ROW, ROW_W'({$urandom, $urandom}));
            queue_random(70);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("stain_colour_deconvolution_core_tb: clean");
        else
            $display("stain_colour_deconvolution_core_tb: errors");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/scd_pkg.sv
sv/scd_coef_regs.sv
sv/scd_density.sv
sv/scd_intensity.sv
sv/stain_colour_deconvolution_core.sv
sv/scd_core_checker.sv
sim/stain_colour_deconvolution_core_tb.sv
